/* src/tccs_pkg.sv */
// Shared constants, codes and types of the text console cursor/scroll engine.
// No dependencies; every other file but tccs_ram refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = CHAR_W + ATTR_W;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned COL_W  = 8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [POS_W-1:0] CELLS_P    = POS_W'(CELLS);
  localparam logic [POS_W-1:0] LAST_CELL  = POS_W'(CELLS - 1);
  localparam logic [POS_W-1:0] COLS_P     = POS_W'(COLUMNS);
  localparam logic [POS_W-1:0] SCROLL_LEN = POS_W'(CELLS - COLUMNS);
  localparam logic [POS_W-1:0] SCROLL_END = POS_W'(CELLS - COLUMNS - 1);
  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_BACK,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } status_t;

endpackage

`default_nettype wire

/* src/tccs_req_if.sv */
// Input channel of the console engine: valid/ready plus one request word.
// Depends on tccs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tccs_req_if;
  logic                        valid;
  logic                        ready;
  logic [tccs_pkg::FUNC_W-1:0] func;
  logic [tccs_pkg::CHAR_W-1:0] char_code;
  logic [tccs_pkg::POS_W-1:0]  cell_index;

  modport source (output valid, func, char_code, cell_index, input ready);
  modport sink   (input valid, func, char_code, cell_index, output ready);
endinterface

`default_nettype wire

/* src/tccs_rsp_if.sv */
// Result channel of the console engine: valid/ready plus one result word.
// Depends on tccs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tccs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tccs_pkg::POS_W-1:0]  cursor_position;
  logic [tccs_pkg::CHAR_W-1:0] cell_char;
  logic [tccs_pkg::ATTR_W-1:0] cell_attr;

  modport source (output valid, cursor_position, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_position, cell_char, cell_attr, output ready);
endinterface

`default_nettype wire

/* src/text_console_cursor_scroll_core.sv */
// Text console engine: a 80x25 screen of character/attribute cells and a cursor.
// req_i carries func (put, clear, read), char_code and cell_index; a word is
// taken when valid and ready are both high. rsp_o returns one word per request:
// the cursor after the request and, for an on-screen read, the cell's bytes.
// cfg_we_i/cfg_data_i load the attribute byte used by put and clear; write it
// only while no request is outstanding.
// A decoder feeds a two-entry command queue; the executor behind it owns the
// screen RAM (one write and one registered read port per cycle).
// A result is registered: a request passes through the queue and then the
// executor's output register; a read also passes the RAM's registered read
// port. Put, backspace, newline and no-op run at one per cycle through the
// executor while the output register is free. A put or newline that runs off
// the last row copies rows up one RAM word per cycle; clear writes one cell
// per cycle. The queue keeps taking requests meanwhile until it is full.
// After reset the executor zeroes the RAM in one pass over every cell with ready low.
// A stalled result holds in the output register; the executor waits for it
// and the queue then fills and drops ready.
// Depends on tccs_pkg, tccs_req_if, tccs_rsp_if, tccs_front, tccs_fifo and
// tccs_back.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tccs_pkg::ATTR_W-1:0] cfg_data_i,
  tccs_req_if.sink                         req_i,
  tccs_rsp_if.source                       rsp_o
);

  tccs_pkg::status_t status;
  tccs_pkg::cmd_t    push_cmd;
  tccs_pkg::cmd_t    head_cmd;
  logic              push, pop, queue_full, head_valid;

  tccs_front u_front (
    .req_i        (req_i),
    .status_i     (status),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  tccs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .cmd_o      (head_cmd)
  );

  tccs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .status_o    (status),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

/* src/tccs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tccs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/tccs_front.sv */
// Front end: accepts request words and decodes them into queue commands.
// Depends on tccs_pkg and tccs_req_if.
`timescale 1ns / 1ps
`default_nettype none

module tccs_front (
  tccs_req_if.sink              req_i,
  input  wire tccs_pkg::status_t status_i,
  input  wire logic              queue_full_i,
  output logic                   push_o,
  output tccs_pkg::cmd_t         cmd_o
);

  assign req_i.ready = !status_i.init_busy && !queue_full_i;
  assign push_o      = req_i.valid && req_i.ready;

  always_comb begin
    cmd_o.ch  = req_i.char_code;
    cmd_o.idx = req_i.cell_index;
    case (req_i.func)
      tccs_pkg::FUNC_PUT: begin
        if (req_i.char_code == tccs_pkg::CH_NUL) begin
          cmd_o.op = tccs_pkg::OP_NOP;
        end else if (req_i.char_code == tccs_pkg::CH_BACKSPACE) begin
          cmd_o.op = tccs_pkg::OP_BACK;
        end else if (req_i.char_code == tccs_pkg::CH_NEWLINE ||
                     req_i.char_code == tccs_pkg::CH_RETURN) begin
          cmd_o.op = tccs_pkg::OP_NEWLINE;
        end else begin
          cmd_o.op = tccs_pkg::OP_PUT;
        end
      end
      tccs_pkg::FUNC_CLEAR: begin
        cmd_o.op = tccs_pkg::OP_CLEAR;
      end
      tccs_pkg::FUNC_READ: begin
        // off-screen reads return zeros, same as a no-op
        if (req_i.cell_index < tccs_pkg::CELLS_P) begin
          cmd_o.op = tccs_pkg::OP_READ;
        end else begin
          cmd_o.op = tccs_pkg::OP_NOP;
        end
      end
      default: begin
        cmd_o.op = tccs_pkg::OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/tccs_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on tccs_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tccs_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tccs_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output tccs_pkg::cmd_t      cmd_o
);

  tccs_pkg::cmd_t                 mem_q [tccs_pkg::QUEUE_DEPTH];
  logic [tccs_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tccs_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tccs_pkg::QCNT_W-1:0]    count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o  = (count_q == tccs_pkg::QCNT_W'(tccs_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* src/tccs_back.sv */
// Back end: owns the cursor, the attribute register and the screen RAM;
// executes queued commands, runs scroll/clear sweeps and drives results.
// Depends on tccs_pkg, tccs_rsp_if and tccs_ram.
`timescale 1ns / 1ps
`default_nettype none

module tccs_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tccs_pkg::ATTR_W-1:0] cfg_data_i,
  input  wire logic                        cmd_valid_i,
  input  wire tccs_pkg::cmd_t              cmd_i,
  output logic                             pop_o,
  output tccs_pkg::status_t                status_o,
  tccs_rsp_if.source                       rsp_o
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } state_e;

  state_e                        state_q, state_d;
  logic                          init_q, init_d;
  logic [tccs_pkg::ATTR_W-1:0]   attr_q, attr_d;
  logic [tccs_pkg::POS_W-1:0]    cursor_q, cursor_d;
  logic [tccs_pkg::POS_W-1:0]    base_q, base_d;
  logic [tccs_pkg::COL_W-1:0]    col_q, col_d;
  logic [tccs_pkg::POS_W-1:0]    ptr_q, ptr_d;
  logic [tccs_pkg::POS_W-1:0]    wptr_q, wptr_d;
  logic                          pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  logic [tccs_pkg::POS_W-1:0]    out_cursor_q, out_cursor_d;
  logic [tccs_pkg::CHAR_W-1:0]   out_char_q, out_char_d;
  logic [tccs_pkg::ATTR_W-1:0]   out_attr_q, out_attr_d;

  logic                          out_free;
  logic                          ram_we, ram_re;
  logic [tccs_pkg::POS_W-1:0]    ram_waddr, ram_raddr;
  logic [tccs_pkg::CELL_W-1:0]   ram_wdata, ram_rdata;
  logic [tccs_pkg::POS_W-1:0]    nx_cursor, nx_base;
  logic [tccs_pkg::COL_W-1:0]    nx_col;
  logic                          rd_act;

  tccs_ram #(
    .WIDTH (tccs_pkg::CELL_W),
    .DEPTH (tccs_pkg::CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free           = !out_valid_q || rsp_o.ready;
  assign status_o.init_busy = init_q;
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.cursor_position = out_cursor_q;
  assign rsp_o.cell_char       = out_char_q;
  assign rsp_o.cell_attr       = out_attr_q;
  assign rd_act = (ptr_q != tccs_pkg::SCROLL_LEN);

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    attr_d       = cfg_we_i ? cfg_data_i : attr_q;
    cursor_d     = cursor_q;
    base_d       = base_q;
    col_d        = col_q;
    ptr_d        = ptr_q;
    wptr_d       = wptr_q;
    pend_d       = 1'b0;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_cursor_d = out_cursor_q;
    out_char_d   = out_char_q;
    out_attr_d   = out_attr_q;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q + tccs_pkg::COLS_P;
    nx_cursor    = cursor_q;
    nx_base      = base_q;
    nx_col       = col_q;

    case (state_q)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = init_q ? '0 : {attr_q, tccs_pkg::CH_NUL};
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == tccs_pkg::LAST_CELL) begin
          state_d = ST_IDLE;
          if (init_q) begin
            init_d = 1'b0;
          end else begin
            out_valid_d  = 1'b1;
            out_cursor_d = cursor_q;
            out_char_d   = '0;
            out_attr_d   = '0;
          end
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            tccs_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = cursor_q;
              ram_wdata = {attr_q, cmd_i.ch};
              nx_cursor = cursor_q + 1'b1;
              if (col_q == tccs_pkg::COL_LAST) begin
                nx_col  = '0;
                nx_base = base_q + tccs_pkg::COLS_P;
              end else begin
                nx_col  = col_q + 1'b1;
              end
            end
            tccs_pkg::OP_BACK: begin
              if (col_q != '0) begin
                nx_cursor = cursor_q - 1'b1;
                nx_col    = col_q - 1'b1;
              end
            end
            tccs_pkg::OP_NEWLINE: begin
              nx_base   = base_q + tccs_pkg::COLS_P;
              nx_cursor = nx_base;
              nx_col    = '0;
            end
            tccs_pkg::OP_CLEAR: begin
              ptr_d   = '0;
              state_d = ST_SWEEP;
            end
            tccs_pkg::OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = cmd_i.idx;
              state_d   = ST_READ;
            end
            default: begin
            end
          endcase

          col_d = nx_col;
          if (nx_cursor == tccs_pkg::CELLS_P) begin
            // cursor ran off the screen: move up a row and start the copy
            cursor_d = nx_cursor - tccs_pkg::COLS_P;
            base_d   = nx_base - tccs_pkg::COLS_P;
            ptr_d    = '0;
            state_d  = ST_SCROLL;
          end else begin
            cursor_d = nx_cursor;
            base_d   = nx_base;
            if (cmd_i.op != tccs_pkg::OP_CLEAR && cmd_i.op != tccs_pkg::OP_READ) begin
              out_valid_d  = 1'b1;
              out_cursor_d = nx_cursor;
              out_char_d   = '0;
              out_attr_d   = '0;
            end
          end
        end
      end

      ST_READ: begin
        state_d      = ST_IDLE;
        out_valid_d  = 1'b1;
        out_cursor_d = cursor_q;
        out_char_d   = ram_rdata[tccs_pkg::CHAR_W-1:0];
        out_attr_d   = ram_rdata[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
      end

      ST_SCROLL: begin
        // read one row ahead, write the word back a row up on the next cycle
        ram_re = rd_act;
        pend_d = rd_act;
        wptr_d = ptr_q;
        if (rd_act) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wptr_q;
          ram_wdata = ram_rdata;
          if (wptr_q == tccs_pkg::SCROLL_END) begin
            state_d      = ST_IDLE;
            out_valid_d  = 1'b1;
            out_cursor_d = cursor_q;
            out_char_d   = '0;
            out_attr_d   = '0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      init_q       <= 1'b1;
      attr_q       <= tccs_pkg::ATTR_RESET;
      cursor_q     <= '0;
      base_q       <= '0;
      col_q        <= '0;
      ptr_q        <= '0;
      wptr_q       <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_cursor_q <= '0;
      out_char_q   <= '0;
      out_attr_q   <= '0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      attr_q       <= attr_d;
      cursor_q     <= cursor_d;
      base_q       <= base_d;
      col_q        <= col_d;
      ptr_q        <= ptr_d;
      wptr_q       <= wptr_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_cursor_q <= out_cursor_d;
      out_char_q   <= out_char_d;
      out_attr_q   <= out_attr_d;
    end
  end

endmodule

`default_nettype wire
